/* hdl/hmm_pkg.sv */
// shared constants, widths and types of the two-state belief update
package hmm_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int WEIGHT_BITS   = 16;

    localparam int PROB_W  = FRACTION_BITS + 1;
    localparam int MUL_B_W = (PROB_W > WEIGHT_BITS) ? PROB_W : WEIGHT_BITS;
    localparam int PROD_W  = PROB_W + MUL_B_W;
    localparam int MIX_W   = 2 * FRACTION_BITS + 1;
    localparam int TERM_W  = FRACTION_BITS + WEIGHT_BITS;
    localparam int QUO_W   = FRACTION_BITS + 2;
    localparam int CNT_W   = (FRACTION_BITS > 1) ? $clog2(FRACTION_BITS) : 1;

    localparam logic [PROB_W-1:0] ONE_Q  = PROB_W'(1) << FRACTION_BITS;
    localparam logic [PROB_W-1:0] HALF_Q = PROB_W'(1) << (FRACTION_BITS - 1);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(FRACTION_BITS - 1);

    typedef logic [1:0] t_cue;
    localparam t_cue CUE_NONE = 2'd0;
    localparam t_cue CUE_STAY = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX_A,
        S_MIX_B,
        S_PRIOR,
        S_TERM_A,
        S_TERM_B,
        S_DIV_INIT,
        S_DIV_STEP,
        S_ROUND
    } t_state;

endpackage

/* hdl/hmm_if.sv */
// valid/ready channel interfaces for input and result beats
interface hmm_in_if;
    logic                                valid;
    logic                                ready;
    logic [hmm_pkg::WEIGHT_BITS-1:0]     lik_one;
    logic [hmm_pkg::WEIGHT_BITS-1:0]     lik_two;
    logic [hmm_pkg::PROB_W-1:0]          hazard;
    logic [1:0]                          cue;
    logic                                last;

    modport source (output valid, lik_one, lik_two, hazard, cue, last, input ready);
    modport sink   (input valid, lik_one, lik_two, hazard, cue, last, output ready);
endinterface

interface hmm_out_if;
    logic                          valid;
    logic                          ready;
    logic [hmm_pkg::PROB_W-1:0]    post_one;
    logic [hmm_pkg::PROB_W-1:0]    post_two;
    logic                          degenerate;

    modport source (output valid, post_one, post_two, degenerate, input ready);
    modport sink   (input valid, post_one, post_two, degenerate, output ready);
endinterface

/* hdl/two_state_hmm_belief_update.sv */
// two-state hidden markov forward filter with per-beat hazard rate
//
// i_in carries one observation beat: two likelihood weights, a Q1.16 hazard,
// a cue and a last flag. o_out carries one result beat per input beat: both
// Q1.16 posteriors and a degenerate flag.
// one shared 17x17 multiplier forms the prior mix and the two weighted
// terms, then one shared compare/subtract unit runs a restoring divide,
// one quotient bit per cycle. an input beat with no cue passes through the
// mix states S_MIX_A, S_MIX_B and S_PRIOR; a cued beat skips those three
// and goes straight to the weighted terms; when both weighted terms are zero
// the divide steps are skipped and the sequencer goes from the divide setup
// straight to rounding; the next beat is accepted in the cycle after the result loads.
// the divide loop runs FRACTION_BITS steps after its initial step.
// i_in.ready is high only while the sequencer is idle.
// the result sits in an output register, so a new beat is accepted while
// the previous result waits; if the receiver still holds the old result
// when the next one is done, the sequencer waits in its rounding step.
// reset (synchronous, active low) empties the output register and sets
// the belief to one half; a beat flagged last also returns it to one half.
module two_state_hmm_belief_update (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hmm_in_if.sink           i_in,
    hmm_out_if.source        o_out
);
    import hmm_pkg::*;

    t_state                  r_state, n_state;
    logic [PROB_W-1:0]       r_belief, n_belief;
    logic [WEIGHT_BITS-1:0]  r_lik_one, n_lik_one;
    logic [WEIGHT_BITS-1:0]  r_lik_two, n_lik_two;
    logic [PROB_W-1:0]       r_hazard, n_hazard;
    logic                    r_last, n_last;
    logic [MIX_W-1:0]        r_mix, n_mix;
    logic [PROB_W-1:0]       r_p1, n_p1;
    logic [TERM_W-1:0]       r_num, n_num;
    logic [TERM_W-1:0]       r_den, n_den;
    logic [TERM_W-1:0]       r_rem, n_rem;
    logic [QUO_W-1:0]        r_quo, n_quo;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_degen, n_degen;
    logic                    r_out_valid, n_out_valid;
    logic [PROB_W-1:0]       r_post_one, n_post_one;
    logic [PROB_W-1:0]       r_post_two, n_post_two;
    logic                    r_out_degen, n_out_degen;

    logic [PROB_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic [TERM_W:0]         cmp_a;
    logic [TERM_W:0]         cmp_den;
    logic [TERM_W:0]         cmp_diff;
    logic                    cmp_ge;
    logic [PROB_W-1:0]       haz_sat;
    logic [MIX_W-1:0]        mix_rnd;
    logic [QUO_W-1:0]        quo_rnd;
    logic [PROB_W-1:0]       post;
    logic                    out_free;

    // shared multiplier
    always_comb begin
        unique case (r_state)
            S_MIX_A: begin
                mul_a = ONE_Q - r_hazard;
                mul_b = MUL_B_W'(r_belief);
            end
            S_MIX_B: begin
                mul_a = r_hazard;
                mul_b = MUL_B_W'(ONE_Q - r_belief);
            end
            S_TERM_A: begin
                mul_a = r_p1;
                mul_b = MUL_B_W'(r_lik_one);
            end
            S_TERM_B: begin
                mul_a = ONE_Q - r_p1;
                mul_b = MUL_B_W'(r_lik_two);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // shared compare/subtract
    always_comb begin
        cmp_a    = (r_state == S_DIV_INIT) ? {1'b0, r_num} : {r_rem, 1'b0};
        cmp_den  = {1'b0, r_den};
        cmp_ge   = cmp_a >= cmp_den;
        cmp_diff = cmp_a - cmp_den;
    end

    assign haz_sat  = (i_in.hazard > ONE_Q) ? ONE_Q : i_in.hazard;
    assign mix_rnd  = r_mix + MIX_W'(HALF_Q);
    assign quo_rnd  = r_quo + QUO_W'(cmp_ge);
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        if (r_degen) begin
            post = r_belief;
        end else if (quo_rnd > QUO_W'(ONE_Q)) begin
            post = ONE_Q;
        end else begin
            post = quo_rnd[PROB_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_belief    = r_belief;
        n_lik_one   = r_lik_one;
        n_lik_two   = r_lik_two;
        n_hazard    = r_hazard;
        n_last      = r_last;
        n_mix       = r_mix;
        n_p1        = r_p1;
        n_num       = r_num;
        n_den       = r_den;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_degen     = r_degen;
        n_out_valid = r_out_valid && !o_out.ready;
        n_post_one  = r_post_one;
        n_post_two  = r_post_two;
        n_out_degen = r_out_degen;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_lik_one = i_in.lik_one;
                    n_lik_two = i_in.lik_two;
                    n_hazard  = haz_sat;
                    n_last    = i_in.last;
                    if (i_in.cue == CUE_NONE) begin
                        n_state = S_MIX_A;
                    end else begin
                        n_p1    = (i_in.cue == CUE_STAY) ? ONE_Q - haz_sat : haz_sat;
                        n_state = S_TERM_A;
                    end
                end
            end
            S_MIX_A: begin
                n_mix   = mul_p[MIX_W-1:0];
                n_state = S_MIX_B;
            end
            S_MIX_B: begin
                n_mix   = r_mix + mul_p[MIX_W-1:0];
                n_state = S_PRIOR;
            end
            S_PRIOR: begin
                n_p1    = mix_rnd[FRACTION_BITS +: PROB_W];
                n_state = S_TERM_A;
            end
            S_TERM_A: begin
                n_num   = mul_p[TERM_W-1:0];
                n_state = S_TERM_B;
            end
            S_TERM_B: begin
                n_den   = r_num + mul_p[TERM_W-1:0];
                n_state = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                n_cnt   = '0;
                n_degen = (r_den == '0);
                n_quo   = QUO_W'(cmp_ge);
                n_rem   = cmp_ge ? cmp_diff[TERM_W-1:0] : r_num;
                n_state = (r_den == '0) ? S_ROUND : S_DIV_STEP;
            end
            S_DIV_STEP: begin
                n_quo = {r_quo[QUO_W-2:0], cmp_ge};
                n_rem = cmp_ge ? cmp_diff[TERM_W-1:0] : cmp_a[TERM_W-1:0];
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_post_one  = post;
                    n_post_two  = ONE_Q - post;
                    n_out_degen = r_degen;
                    n_belief    = r_last ? HALF_Q : post;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_belief    <= HALF_Q;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_belief    <= n_belief;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lik_one   <= n_lik_one;
        r_lik_two   <= n_lik_two;
        r_hazard    <= n_hazard;
        r_last      <= n_last;
        r_mix       <= n_mix;
        r_p1        <= n_p1;
        r_num       <= n_num;
        r_den       <= n_den;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_cnt       <= n_cnt;
        r_degen     <= n_degen;
        r_post_one  <= n_post_one;
        r_post_two  <= n_post_two;
        r_out_degen <= n_out_degen;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.post_one   = r_post_one;
    assign o_out.post_two   = r_post_two;
    assign o_out.degenerate = r_out_degen;

endmodule

/* bench/tb_top.sv */
// self-checking testbench of the two-state hmm belief update over random handshakes
module tb_top;
    import hmm_pkg::*;

    localparam t_cue CUE_SWITCH     = 2'd2;
    localparam t_cue CUE_SWITCH_ALT = 2'd3;

    localparam logic [63:0] UNITY = 64'(ONE_Q);
    localparam logic [63:0] HALF  = 64'(HALF_Q);

    localparam int RANDOM_PER_PHASE = 177;
    localparam int HOLD_CYCLES      = 400;
    localparam int DRAIN_LIMIT      = 20000;

    typedef struct {
        logic [WEIGHT_BITS-1:0] lik_one;
        logic [WEIGHT_BITS-1:0] lik_two;
        logic [PROB_W-1:0]      hazard;
        t_cue                   cue;
        logic                   last;
    } obs_t;

    typedef struct {
        logic [PROB_W-1:0] post_one;
        logic [PROB_W-1:0] post_two;
        logic              degenerate;
    } posterior_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hmm_in_if  obs_if ();
    hmm_out_if post_if ();

    two_state_hmm_belief_update dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (obs_if),
        .o_out   (post_if)
    );

    always #4 i_clk = ~i_clk;

    obs_t        obs_pending[$];
    posterior_t  posterior_q[$];
    logic [63:0] kept_belief;
    bit          obs_taken;
    bit          hold_armed;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          items_queued;
    int          results_seen;
    int          errors;

    function automatic posterior_t predict_posterior(input obs_t o);
        logic [63:0] h;
        logic [63:0] b;
        logic [63:0] p1;
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] z;
        logic [63:0] post;
        posterior_t  r;
        h = 64'(o.hazard);
        if (h > UNITY) h = UNITY;
        b = kept_belief;
        if (b > UNITY) b = UNITY;
        case (o.cue)
            CUE_NONE: begin
                p1 = ((UNITY - h) * b + h * (UNITY - b) + HALF) >> FRACTION_BITS;
                if (p1 > UNITY) p1 = UNITY;
            end
            CUE_STAY: p1 = UNITY - h;
            default:  p1 = h;
        endcase
        t1 = p1 * 64'(o.lik_one);
        t2 = (UNITY - p1) * 64'(o.lik_two);
        z  = t1 + t2;
        if (z == 0) begin
            post = b;
        end else begin
            // nearest quotient, ties up
            post = ((t1 << (FRACTION_BITS + 1)) + z) / (z << 1);
            if (post > UNITY) post = UNITY;
        end
        r.post_one   = post[PROB_W-1:0];
        r.post_two   = ONE_Q - post[PROB_W-1:0];
        r.degenerate = (z == 0);
        kept_belief  = o.last ? HALF : post;
        return r;
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] random_weight();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        if (sel == 2) return WEIGHT_BITS'($urandom_range(0, 15));
        return WEIGHT_BITS'($urandom);
    endfunction

    function automatic obs_t random_obs();
        obs_t o;
        int   sel;
        o.lik_one = random_weight();
        o.lik_two = random_weight();
        sel = $urandom_range(0, 19);
        if (sel < 2)      o.hazard = PROB_W'($urandom_range(65537, 131071));
        else if (sel < 3) o.hazard = ONE_Q;
        else if (sel < 8) o.hazard = PROB_W'($urandom_range(0, 2000));
        else              o.hazard = PROB_W'($urandom_range(0, 65535));
        o.cue  = ($urandom_range(0, 9) < 6) ? CUE_NONE : t_cue'($urandom_range(1, 3));
        o.last = ($urandom_range(0, 11) == 0);
        return o;
    endfunction

    task automatic push_obs(input int l1, input int l2, input int h, input t_cue c,
                            input bit lst);
        obs_t o;
        o.lik_one = WEIGHT_BITS'(l1);
        o.lik_two = WEIGHT_BITS'(l2);
        o.hazard  = PROB_W'(h);
        o.cue     = c;
        o.last    = lst;
        obs_pending.push_back(o);
        items_queued++;
    endtask

    task automatic drain();
        int n;
        n = 0;
        while (results_seen != items_queued && n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
    endtask

    // input driver and receiver ready
    always @(negedge i_clk) begin
        if (!obs_if.valid || obs_taken) begin
            obs_taken = 1'b0;
            if (obs_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                obs_if.lik_one <= obs_pending[0].lik_one;
                obs_if.lik_two <= obs_pending[0].lik_two;
                obs_if.hazard  <= obs_pending[0].hazard;
                obs_if.cue     <= obs_pending[0].cue;
                obs_if.last    <= obs_pending[0].last;
                obs_if.valid   <= 1'b1;
                void'(obs_pending.pop_front());
            end else begin
                obs_if.valid <= 1'b0;
            end
        end
        post_if.ready <= !hold_armed && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        obs_t       o;
        posterior_t want;
        if (i_rst_n) begin
            if (post_if.valid && post_if.ready) begin
                if (posterior_q.size() == 0) begin
                    $display("%0t unexpected result beat: post_one %0d post_two %0d degenerate %0d",
                             $time, post_if.post_one, post_if.post_two, post_if.degenerate);
                    errors++;
                end else begin
                    want = posterior_q.pop_front();
                    results_seen++;
                    if (post_if.post_one !== want.post_one) begin
                        $display("%0t post_one expected %0d actual %0d",
                                 $time, want.post_one, post_if.post_one);
                        errors++;
                    end
                    if (post_if.post_two !== want.post_two) begin
                        $display("%0t post_two expected %0d actual %0d",
                                 $time, want.post_two, post_if.post_two);
                        errors++;
                    end
                    if (post_if.degenerate !== want.degenerate) begin
                        $display("%0t degenerate expected %0d actual %0d",
                                 $time, want.degenerate, post_if.degenerate);
                        errors++;
                    end
                end
            end
            if (obs_if.valid && obs_if.ready) begin
                o.lik_one = obs_if.lik_one;
                o.lik_two = obs_if.lik_two;
                o.hazard  = obs_if.hazard;
                o.cue     = obs_if.cue;
                o.last    = obs_if.last;
                posterior_q.push_back(predict_posterior(o));
                obs_taken = 1'b1;
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (hold_armed);
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_armed = 1'b0;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int send_pcts[5];
        int recv_pcts[5];
        int ph;
        send_pcts = '{0, 56, 0, 26, 0};
        recv_pcts = '{0, 0, 56, 26, 0};
        i_rst_n        = 1'b0;
        obs_if.valid   = 1'b0;
        obs_if.lik_one = '0;
        obs_if.lik_two = '0;
        obs_if.hazard  = '0;
        obs_if.cue     = CUE_NONE;
        obs_if.last    = 1'b0;
        post_if.ready  = 1'b0;
        kept_belief    = HALF;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_obs(1000, 1000, 0, CUE_NONE, 0);
        push_obs(65535, 0, 0, CUE_NONE, 0);
        // prior pinned at one, no weight for state one: belief held
        push_obs(0, 65535, 0, CUE_NONE, 0);
        push_obs(5, 5, 65536, CUE_NONE, 1);
        push_obs(0, 0, 0, CUE_STAY, 0);
        push_obs(65535, 65535, 65536, CUE_SWITCH, 0);
        // hazard above one saturates
        push_obs(300, 700, 131071, CUE_NONE, 0);
        push_obs(40000, 40000, 65537, CUE_STAY, 0);
        push_obs(40000, 123, 20000, CUE_SWITCH_ALT, 0);
        push_obs(65535, 65535, 32768, CUE_NONE, 0);
        push_obs(1, 65535, 1, CUE_SWITCH, 0);
        push_obs(65535, 1, 65535, CUE_STAY, 0);
        push_obs(0, 0, 65535, CUE_NONE, 1);
        push_obs(0, 9, 0, CUE_NONE, 0);
        // belief at zero, no weight for state two
        push_obs(7, 0, 0, CUE_NONE, 0);
        push_obs(12345, 54321, 98304, CUE_SWITCH_ALT, 1);
        push_obs(65535, 65535, 0, CUE_STAY, 0);
        push_obs(1, 1, 65536, CUE_NONE, 0);
        drain();

        for (ph = 0; ph < 5; ph++) begin
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            if (ph == 4) hold_armed = 1'b1;
            repeat (RANDOM_PER_PHASE) begin
                obs_pending.push_back(random_obs());
                items_queued++;
            end
            drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (40) @(negedge i_clk);
        if (results_seen != items_queued || posterior_q.size() != 0) begin
            $display("%0t results outstanding: expected %0d got %0d",
                     $time, items_queued, results_seen);
            errors++;
        end
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
